// ===== rtl/sur_pkg.sv =====
// Shared types, codes and constants of the sequenced upload receiver.
// No dependencies.
package sur_pkg;

	localparam logic [1:0] CMD_HDR  = 2'd0;
	localparam logic [1:0] CMD_DATA = 2'd1;
	localparam logic [1:0] CMD_UNK  = 2'd2;
	localparam logic [1:0] CMD_TICK = 2'd3;

	localparam logic [1:0] KIND_RETX   = 2'd0;
	localparam logic [1:0] KIND_ACK    = 2'd1;
	localparam logic [1:0] KIND_HDRREQ = 2'd2;

	localparam logic REG_TIMEOUT  = 1'b0;
	localparam logic REG_INTERVAL = 1'b1;

	localparam logic [15:0] TIMEOUT_RST  = 16'd60000;
	localparam logic [15:0] INTERVAL_RST = 16'd1001;

	localparam int BUFFER_ROWS = 65536;
	localparam int ROW_BYTES   = 1024;

	localparam int SEQ_W = 17;

	typedef logic [1:0] item_kind_t;
	localparam item_kind_t IT_TICK = 2'd0;
	localparam item_kind_t IT_DROP = 2'd1;
	localparam item_kind_t IT_HDR  = 2'd2;
	localparam item_kind_t IT_DATA = 2'd3;

	typedef struct packed {
		item_kind_t        kind;
		logic [SEQ_W-1:0]  seq;
		logic [10:0]       plen;
	} item_t;

	typedef struct packed {
		logic              store_valid;
		logic [15:0]       store_row;
		logic              reply_valid;
		logic [1:0]        reply_kind;
		logic [SEQ_W-1:0]  reply_number;
		logic [6:0]        progress_percent;
		logic              transfer_done;
		logic              dropped;
		logic              timed_out;
		logic              port_free;
	} result_t;

	// x / 10 for 17-bit x by reciprocal multiply, exact below 2^18
	function automatic logic [SEQ_W-1:0] div10(input logic [SEQ_W-1:0] x);
		logic [33:0] prod;
		prod = 34'(x) * 34'd104858;
		return SEQ_W'(prod[33:20]);
	endfunction

endpackage

// ===== rtl/sur_in_if.sv =====
// Input channel of the upload receiver: packet descriptors and ticks.
// No dependencies.
interface sur_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic        length_ok;
	logic [16:0] seq_number;
	logic [10:0] payload_len;

	modport source(output valid, cmd, length_ok, seq_number, payload_len, input ready);
	modport sink(input valid, cmd, length_ok, seq_number, payload_len, output ready);
endinterface

// ===== rtl/sur_out_if.sv =====
// Result channel of the upload receiver.
// No dependencies.
interface sur_out_if;
	logic        valid;
	logic        ready;
	logic        store_valid;
	logic [15:0] store_row;
	logic        reply_valid;
	logic [1:0]  reply_kind;
	logic [16:0] reply_number;
	logic [6:0]  progress_percent;
	logic        transfer_done;
	logic        dropped;
	logic        timed_out;
	logic        port_free;

	modport source(output valid, store_valid, store_row, reply_valid, reply_kind,
		reply_number, progress_percent, transfer_done, dropped, timed_out, port_free,
		input ready);
	modport sink(input valid, store_valid, store_row, reply_valid, reply_kind,
		reply_number, progress_percent, transfer_done, dropped, timed_out, port_free,
		output ready);
endinterface

// ===== rtl/sur_front.sv =====
// Front end: accepts items, classifies them and holds them in a two-entry queue.
// Depends on sur_pkg and sur_in_if.
module sur_front (
	input  logic          clk,
	input  logic          arst_n,
	sur_in_if.sink        in_ch,
	output sur_pkg::item_t head,
	output logic          head_valid,
	input  logic          pop
);
	import sur_pkg::*;

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      entry;
	logic       push;
	logic       do_pop;

	always_comb begin
		entry.seq  = in_ch.seq_number;
		entry.plen = in_ch.payload_len;
		priority if (in_ch.cmd == CMD_TICK) entry.kind = IT_TICK;
		else if (!in_ch.length_ok || in_ch.cmd == CMD_UNK) entry.kind = IT_DROP;
		else if (in_ch.cmd == CMD_HDR) entry.kind = IT_HDR;
		else entry.kind = IT_DATA;
	end

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign head_valid  = (cnt_q != 2'd0);
	assign head        = mem_q[rd_ptr_q];
	assign do_pop      = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(do_pop);
		end
	end

endmodule

// ===== rtl/sur_div.sv =====
// Radix-2 restoring divider: one dividend against two divisors, one bit a cycle.
// Depends on sur_pkg.
module sur_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sur_pkg::SEQ_W-1:0] dividend,
	input  logic [sur_pkg::SEQ_W-1:0] div_a,
	input  logic [15:0]               div_b,
	output logic                      done,
	output logic [sur_pkg::SEQ_W-1:0] quo_a,
	output logic [sur_pkg::SEQ_W-1:0] rem_a,
	output logic [15:0]               rem_b
);
	import sur_pkg::*;

	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [SEQ_W-1:0] num_q;
	logic [SEQ_W-1:0] quo_q;
	logic [SEQ_W-1:0] ra_q;
	logic [15:0]      rb_q;
	logic [SEQ_W-1:0] da_q;
	logic [15:0]      db_q;
	logic [SEQ_W:0]   ta;
	logic [16:0]      tb;
	logic             qa;
	logic [SEQ_W-1:0] ra_d;
	logic [15:0]      rb_d;

	always_comb begin
		ta = {ra_q, num_q[SEQ_W-1]};
		tb = {rb_q, num_q[SEQ_W-1]};
		qa = (ta >= {1'b0, da_q});
		ra_d = qa ? SEQ_W'(ta - {1'b0, da_q}) : ta[SEQ_W-1:0];
		rb_d = (tb >= {1'b0, db_q}) ? 16'(tb - {1'b0, db_q}) : tb[15:0];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			da_q  <= div_a;
			db_q  <= div_b;
			ra_q  <= '0;
			rb_q  <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[SEQ_W-2:0], 1'b0};
			ra_q  <= ra_d;
			rb_q  <= rb_d;
			quo_q <= {quo_q[SEQ_W-2:0], qa};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(SEQ_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done  = done_q;
	assign quo_a = quo_q;
	assign rem_a = ra_q;
	assign rem_b = rb_q;

endmodule

// ===== rtl/sur_back.sv =====
// Back end: transfer state, timer, progress checks and the result register.
// Depends on sur_pkg, sur_out_if and sur_div.
module sur_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [15:0]    cfg_data,
	input  sur_pkg::item_t head,
	input  logic           head_valid,
	output logic           pop,
	sur_out_if.source      out_ch
);
	import sur_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic             state_q;
	logic [15:0]      timeout_q;
	logic [15:0]      interval_q;
	logic [SEQ_W-1:0] next_q;
	logic             hdr_miss_q;
	logic [SEQ_W-1:0] last_q;
	logic [SEQ_W-1:0] step_q;
	logic             pend_q;
	logic             free_q;
	logic [15:0]      idle_q;
	logic             run_q;
	logic             out_valid_q;
	result_t          res_q;

	logic [SEQ_W-1:0] next_d, last_d, step_d;
	logic             hdr_d, pend_d, free_d, run_d, go_div;
	logic [15:0]      idle_d, inc;
	result_t          res_d;

	logic             div_done;
	logic [SEQ_W-1:0] quo_a, rem_a;
	logic [15:0]      rem_b;
	logic             hit;

	assign pop = (state_q == ST_IDLE) && head_valid && (!out_valid_q || out_ch.ready);

	always_comb begin
		res_d  = '0;
		next_d = next_q;
		last_d = last_q;
		step_d = step_q;
		hdr_d  = hdr_miss_q;
		pend_d = pend_q;
		free_d = free_q;
		run_d  = run_q;
		idle_d = idle_q;
		go_div = 1'b0;
		inc    = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
		unique case (head.kind)
			IT_TICK: begin
				if (run_q) begin
					idle_d = inc;
					if (inc >= timeout_q) begin
						run_d  = 1'b0;
						idle_d = '0;
						pend_d = 1'b0;
						last_d = '0;
						step_d = '0;
						free_d = 1'b1;
						res_d.timed_out = 1'b1;
					end
				end
			end
			IT_DROP: res_d.dropped = 1'b1;
			IT_HDR: begin
				hdr_d  = 1'b0;
				next_d = '0;
				last_d = (head.seq == '0) ? '0 : head.seq - 1'b1;
				step_d = div10((head.seq == '0) ? SEQ_W'(1) : head.seq);
				run_d  = 1'b1;
				idle_d = '0;
			end
			IT_DATA: begin
				if (!hdr_miss_q && head.seq == next_q) begin
					if (32'(next_q) >= 32'(BUFFER_ROWS) || 32'(head.plen) > 32'(ROW_BYTES)) begin
						res_d.dropped = 1'b1;
					end else begin
						res_d.store_valid = 1'b1;
						res_d.store_row   = next_q[15:0];
						next_d = next_q + 1'b1;
						pend_d = 1'b0;
						free_d = 1'b0;
						if (next_d > last_q) begin
							// upload complete
							res_d.reply_valid      = 1'b1;
							res_d.reply_kind       = KIND_ACK;
							res_d.reply_number     = head.seq;
							res_d.progress_percent = 7'd100;
							res_d.transfer_done    = 1'b1;
							idle_d = '0;
						end else if (step_q != '0) begin
							go_div = 1'b1;
						end
					end
				end else if (pend_q) begin
					// silent until progress resumes
				end else if (!hdr_miss_q && head.seq < next_q) begin
					pend_d = 1'b1;
					res_d.reply_valid  = 1'b1;
					res_d.reply_kind   = KIND_ACK;
					res_d.reply_number = next_q;
				end else if (hdr_miss_q || last_q == '0) begin
					pend_d = 1'b1;
					res_d.reply_valid = 1'b1;
					res_d.reply_kind  = KIND_HDRREQ;
				end else begin
					pend_d = 1'b1;
					res_d.reply_valid  = 1'b1;
					res_d.reply_kind   = KIND_RETX;
					res_d.reply_number = next_q;
					idle_d = '0;
				end
			end
			default: ;
		endcase
		res_d.port_free = free_d;
	end

	sur_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (pop && go_div),
		.dividend (next_d),
		.div_a    (step_q),
		.div_b    (interval_q),
		.done     (div_done),
		.quo_a    (quo_a),
		.rem_a    (rem_a),
		.rem_b    (rem_b)
	);

	assign hit = (rem_a == '0) ||
		(interval_q != '0 && next_q > SEQ_W'(interval_q) && rem_b == '0);

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end else if (state_q == ST_DIV && div_done && hit && quo_a != SEQ_W'(10)) begin
			res_q.reply_valid  <= 1'b1;
			res_q.reply_kind   <= KIND_ACK;
			// the in-order seq is one below the advanced count
			res_q.reply_number <= next_q - 1'b1;
			res_q.progress_percent <= (quo_a > SEQ_W'(10)) ? 7'd100 :
				7'(quo_a[3:0]) * 7'd10;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			timeout_q   <= TIMEOUT_RST;
			interval_q  <= INTERVAL_RST;
			next_q      <= '0;
			hdr_miss_q  <= 1'b1;
			last_q      <= '0;
			step_q      <= '0;
			pend_q      <= 1'b0;
			free_q      <= 1'b1;
			idle_q      <= '0;
			run_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TIMEOUT:  timeout_q  <= cfg_data;
					REG_INTERVAL: interval_q <= cfg_data;
				endcase
			end
			if (out_valid_q && out_ch.ready && !pop)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						next_q     <= next_d;
						last_q     <= last_d;
						step_q     <= step_d;
						hdr_miss_q <= hdr_d;
						pend_q     <= pend_d;
						free_q     <= free_d;
						run_q      <= run_d;
						idle_q     <= idle_d;
						if (go_div) begin
							state_q     <= ST_DIV;
							out_valid_q <= 1'b0;
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (hit)
							idle_q <= '0;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.store_valid      = res_q.store_valid;
	assign out_ch.store_row        = res_q.store_row;
	assign out_ch.reply_valid      = res_q.reply_valid;
	assign out_ch.reply_kind       = res_q.reply_kind;
	assign out_ch.reply_number     = res_q.reply_number;
	assign out_ch.progress_percent = res_q.progress_percent;
	assign out_ch.transfer_done    = res_q.transfer_done;
	assign out_ch.dropped          = res_q.dropped;
	assign out_ch.timed_out        = res_q.timed_out;
	assign out_ch.port_free        = res_q.port_free;

endmodule

// ===== rtl/sequenced_upload_receiver.sv =====
// Sequenced upload receiver: packet classification front, state back end.
// Depends on sur_pkg, sur_in_if, sur_out_if, sur_front and sur_back.
//
// in_ch carries one descriptor per packet (header, data, unknown) or one
// timer tick; out_ch returns exactly one result item per input item, in
// order. cfg_we/cfg_index/cfg_data write the idle timeout (index 0) and the
// extra acknowledge interval (index 1), one register per cycle.
// Ticks, headers, drops and data that needs no progress check pass through
// the queue and the result register, one item per cycle while out_ch is
// ready. An in-order data packet that needs the tenth/interval check runs
// the shared 17-iteration radix-2 divider, and the back end takes no further
// item until the divider is done.
// A two-entry queue parts front and back, so in_ch keeps accepting while a
// result waits on a stalled out_ch; once the queue is full in_ch.ready
// drops until the sink takes the result.
// Reset (arst_n low) empties the queue, drops any pending result, restores
// both registers to their defaults and leaves the receiver waiting for a
// header.
module sequenced_upload_receiver (
	input  logic        clk,
	input  logic        arst_n,
	sur_in_if.sink      in_ch,
	sur_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import sur_pkg::*;

	item_t head;
	logic  head_valid;
	logic  pop;

	sur_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	sur_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_ch     (out_ch)
	);

	a_store_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.store_valid |-> !out_ch.dropped && !out_ch.timed_out)
		else $error("store together with drop or timeout");

	a_done_ack: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.transfer_done |->
			out_ch.store_valid && out_ch.reply_valid &&
			out_ch.reply_kind == KIND_ACK && out_ch.progress_percent == 7'd100)
		else $error("completion without final acknowledge");

	a_no_reply_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.reply_valid |->
			out_ch.reply_number == '0 && out_ch.progress_percent == '0)
		else $error("reply fields set without a reply");

	a_timeout_frees: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.timed_out |-> out_ch.port_free && !out_ch.reply_valid)
		else $error("timeout did not free the port");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of sequenced_upload_receiver: random uploads with dups, gaps,
// drops and ticks, checked item by item against an in-bench predictor.
// Depends on sur_pkg, sur_in_if, sur_out_if and the receiver RTL.
`timescale 1ns / 100ps

module testbench;
	import sur_pkg::*;

	typedef struct {
		logic [1:0]  cmd;
		logic        lok;
		logic [16:0] seq;
		logic [10:0] plen;
	} pkt_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	sur_in_if  in_ch();
	sur_out_if out_ch();

	sequenced_upload_receiver dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// receiver state as predicted
	int unsigned rx_next, rx_last, rx_idle, rx_finlen, rx_timeout, rx_interval;
	bit          rx_nohdr, rx_reqpend, rx_free, rx_running;

	pkt_t    pending_pkts[$];
	result_t expected_results[$];
	pkt_t    drv_pkt;
	result_t got;
	result_t want;
	int      errors = 0;
	int      pkts_in = 0;
	int      results_out = 0;
	int      quiet_cycles = 0;
	int      src_gap = 0;
	int      snk_gap = 0;
	int      hold_left = 0;
	bit      hold_done = 0;
	bit      calm = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void reply(ref result_t r, input logic [1:0] kind,
			input int unsigned num);
		r.reply_valid  = 1'b1;
		r.reply_kind   = kind;
		r.reply_number = num[16:0];
	endfunction

	// progress / completion acknowledges after an in-order store
	function automatic void progress_ack(ref result_t r, input int unsigned seq,
			input int unsigned plen);
		int unsigned n, step, pct;
		bit hit;
		n    = rx_next;
		step = (rx_last + 1) / 10;
		hit  = 0;
		if (n > rx_last) begin
			reply(r, KIND_ACK, seq);
			r.progress_percent = 7'd100;
			r.transfer_done    = 1'b1;
			rx_finlen = plen;
			rx_idle   = 0;
			return;
		end
		if (step == 0)
			return;
		if (n % step == 0)
			hit = 1;
		else if (rx_interval != 0 && n > rx_interval && n % rx_interval == 0)
			hit = 1;
		if (!hit)
			return;
		pct = 10 * (n / step);
		if (pct != 100) begin
			reply(r, KIND_ACK, seq);
			r.progress_percent = pct > 100 ? 7'd100 : pct[6:0];
		end
		rx_idle = 0;
	endfunction

	function automatic result_t predict_result(pkt_t p);
		result_t r;
		int unsigned seq;
		r   = '0;
		seq = p.seq;
		if (p.cmd == CMD_TICK) begin
			if (rx_running) begin
				if (rx_idle < 65535)
					rx_idle++;
				if (rx_idle >= rx_timeout) begin
					rx_running = 0;
					rx_idle    = 0;
					rx_reqpend = 0;
					rx_last    = 0;
					rx_free    = 1;
					r.timed_out = 1'b1;
				end
			end
		end else if (!p.lok || p.cmd == CMD_UNK) begin
			r.dropped = 1'b1;
		end else if (p.cmd == CMD_HDR) begin
			rx_nohdr   = 0;
			rx_next    = 0;
			rx_last    = seq == 0 ? 0 : seq - 1;
			rx_running = 1;
			rx_idle    = 0;
		end else if (!rx_nohdr && seq == rx_next) begin
			if (rx_next >= BUFFER_ROWS || p.plen > ROW_BYTES) begin
				r.dropped = 1'b1;
			end else begin
				r.store_valid = 1'b1;
				r.store_row   = rx_next[15:0];
				rx_next    = (rx_next + 1) & 32'h1FFFF;
				rx_reqpend = 0;
				rx_free    = 0;
				progress_ack(r, seq, p.plen);
			end
		end else if (rx_reqpend) begin
			// silent until an in-order item arrives
		end else if (!rx_nohdr && seq < rx_next) begin
			rx_reqpend = 1;
			reply(r, KIND_ACK, rx_next);
		end else if (rx_nohdr || rx_last == 0) begin
			rx_reqpend = 1;
			reply(r, KIND_HDRREQ, 0);
		end else begin
			rx_reqpend = 1;
			reply(r, KIND_RETX, rx_next);
			rx_idle = 0;
		end
		r.port_free = rx_free;
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				in_ch.valid <= 1'b0;
			end else if (pending_pkts.size() > 0 && (calm || $urandom_range(0, 11) != 0)) begin
				drv_pkt = pending_pkts.pop_front();
				in_ch.valid       <= 1'b1;
				in_ch.cmd         <= drv_pkt.cmd;
				in_ch.length_ok   <= drv_pkt.lok;
				in_ch.seq_number  <= drv_pkt.seq;
				in_ch.payload_len <= drv_pkt.plen;
			end else begin
				if (pending_pkts.size() > 0)
					src_gap <= $urandom_range(0, 12);
				in_ch.valid <= 1'b0;
			end
		end
	end

	// result sink, with one long hold-off to back the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else if (!hold_done && pkts_in >= 300) begin
			hold_done <= 1'b1;
			hold_left <= 250;
			out_ch.ready <= 1'b0;
		end else if (snk_gap > 0) begin
			snk_gap <= snk_gap - 1;
			out_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			snk_gap <= $urandom_range(0, 12);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	// monitor and scoreboard
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			expected_results.push_back(predict_result('{in_ch.cmd, in_ch.length_ok,
				in_ch.seq_number, in_ch.payload_len}));
			pkts_in++;
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_out++;
			got = '{out_ch.store_valid, out_ch.store_row, out_ch.reply_valid,
				out_ch.reply_kind, out_ch.reply_number, out_ch.progress_percent,
				out_ch.transfer_done, out_ch.dropped, out_ch.timed_out, out_ch.port_free};
			if (expected_results.size() == 0) begin
				$error("result item with nothing expected");
				errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("store_valid", want.store_valid, got.store_valid);
				check_field("store_row", want.store_row, got.store_row);
				check_field("reply_valid", want.reply_valid, got.reply_valid);
				check_field("reply_kind", want.reply_kind, got.reply_kind);
				check_field("reply_number", want.reply_number, got.reply_number);
				check_field("progress_percent", want.progress_percent,
					got.progress_percent);
				check_field("transfer_done", want.transfer_done, got.transfer_done);
				check_field("dropped", want.dropped, got.dropped);
				check_field("timed_out", want.timed_out, got.timed_out);
				check_field("port_free", want.port_free, got.port_free);
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 4000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic void push_pkt(logic [1:0] cmd, logic lok, int unsigned seq,
			int unsigned plen);
		pkt_t p;
		p.cmd  = cmd;
		p.lok  = lok;
		p.seq  = seq[16:0];
		p.plen = plen[10:0];
		pending_pkts.push_back(p);
	endfunction

	// one upload: header then mostly in-order data, with disturbances
	function automatic int queue_upload();
		int unsigned total, i, sel;
		int n;
		sel = $urandom_range(0, 99);
		if (sel < 5)
			total = 0;
		else if (sel < 75)
			total = $urandom_range(1, 40);
		else
			total = $urandom_range(41, 200);
		push_pkt(CMD_HDR, 1'b1, total, $urandom_range(0, 1024));
		n = 1;
		for (i = 0; i < total; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 3)
				push_pkt(CMD_DATA, 1'b1, $urandom_range(0, i), $urandom_range(0, 1024));
			else if (sel < 6)
				push_pkt(CMD_DATA, 1'b1, $urandom_range(i + 1, i + 5), $urandom_range(0, 1024));
			else if (sel < 12)
				push_pkt(CMD_TICK, 1'($urandom_range(0, 1)), $urandom_range(0, 65536),
					$urandom_range(0, 1024));
			else if (sel < 14)
				push_pkt(CMD_DATA, 1'b0, i, $urandom_range(0, 1024));
			else if (sel < 15)
				push_pkt(CMD_UNK, 1'b1, i, $urandom_range(0, 1024));
			if (sel < 15)
				n++;
			push_pkt(CMD_DATA, 1'b1, i, $urandom_range(0, 1024));
			n++;
		end
		return n;
	endfunction

	function automatic void queue_noise(int count);
		for (int k = 0; k < count; k++)
			push_pkt(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				$urandom_range(0, 65536), $urandom_range(0, 1024));
	endfunction

	task automatic wait_drained();
		wait (pending_pkts.size() == 0 && expected_results.size() == 0 && !in_ch.valid);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_regs(int unsigned timeout_v, int unsigned interval_v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TIMEOUT;
		cfg_data  <= timeout_v[15:0];
		@(posedge clk);
		cfg_index <= REG_INTERVAL;
		cfg_data  <= interval_v[15:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		rx_timeout  = timeout_v;
		rx_interval = interval_v;
	endtask

	task automatic random_phase(int budget, bit last_phase);
		int n;
		n = 0;
		while (n < budget) begin
			if ($urandom_range(0, 9) < 8)
				n += queue_upload();
			else begin
				queue_noise(8);
				n += 8;
			end
		end
		if (last_phase) begin
			wait (pending_pkts.size() < 150);
			@(negedge clk);
			calm = 1;
		end
		wait_drained();
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_TIMEOUT;
		cfg_data  = '0;
		in_ch.valid       = 1'b0;
		in_ch.cmd         = CMD_TICK;
		in_ch.length_ok   = 1'b0;
		in_ch.seq_number  = '0;
		in_ch.payload_len = '0;
		out_ch.ready      = 1'b0;
		rx_next = 0; rx_last = 0; rx_idle = 0; rx_finlen = 0;
		rx_nohdr = 1; rx_reqpend = 0; rx_free = 1; rx_running = 0;
		rx_timeout  = TIMEOUT_RST;
		rx_interval = INTERVAL_RST;
		repeat (4) @(posedge clk);
		arst_n = 1'b1;

		// directed: defaults in force
		push_pkt(CMD_DATA, 1'b1, 0, 10);        // data before header
		push_pkt(CMD_DATA, 1'b1, 3, 10);        // request already pending
		push_pkt(CMD_TICK, 1'b0, 0, 0);         // tick with timer stopped
		push_pkt(CMD_HDR, 1'b0, 5, 0);          // bad length
		push_pkt(CMD_UNK, 1'b1, 5, 0);          // unknown type
		push_pkt(CMD_HDR, 1'b1, 0, 0);          // zero count saturates
		push_pkt(CMD_DATA, 1'b1, 0, 1024);      // completes at once
		push_pkt(CMD_HDR, 1'b1, 1, 0);
		push_pkt(CMD_DATA, 1'b1, 4, 0);         // gap with last number zero
		push_pkt(CMD_HDR, 1'b1, 20, 2047 & 1024);
		push_pkt(CMD_DATA, 1'b1, 0, 0);
		push_pkt(CMD_DATA, 1'b1, 1, 512);       // tenth reached
		push_pkt(CMD_DATA, 1'b1, 0, 5);         // duplicate
		push_pkt(CMD_DATA, 1'b1, 0, 5);         // silent
		push_pkt(CMD_DATA, 1'b1, 2, 1023);
		push_pkt(CMD_DATA, 1'b1, 9, 7);         // gap
		push_pkt(CMD_DATA, 1'b1, 65536, 7);
		push_pkt(CMD_TICK, 1'b1, 65536, 1024);
		push_pkt(CMD_HDR, 1'b1, 65536, 1024);
		push_pkt(CMD_DATA, 1'b1, 0, 1024);
		push_pkt(CMD_HDR, 1'b1, 19, 0);         // percent above 100 ahead
		for (int k = 0; k < 18; k++)
			push_pkt(CMD_DATA, 1'b1, k, k);
		wait_drained();

		random_phase(400, 0);
		write_regs(1, 1);
		random_phase(400, 0);
		write_regs(65535, 65535);
		random_phase(300, 0);
		write_regs($urandom_range(2, 20), $urandom_range(2, 7));
		random_phase(500, 1);

		if (errors == 0 && expected_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/sur_pkg.sv
rtl/sur_in_if.sv
rtl/sur_out_if.sv
rtl/sur_front.sv
rtl/sur_div.sv
rtl/sur_back.sv
rtl/sequenced_upload_receiver.sv
tb/sv/testbench.sv
